// ===== src/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the seven-segment scanner
// Word layouts, command and register codes, digit codes and the segment table.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int NUMBER_WIDTH   = 32;
  localparam int MAX_DIGITS_DEF = 8;
  localparam int CODE_W         = 5;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 4;

  // Commands carried by an input word
  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEX_MODE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FILL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_SIGN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_SEG  = 3'd4;

  localparam logic [CODE_W-1:0] MINUS_CODE  = 5'd16;
  localparam logic [7:0]        POINT_BIT   = 8'h80;
  localparam logic [7:0]        NO_POINT    = 8'hFF;
  localparam logic [3:0]        DIGITS_RST  = 4'd4;

  typedef struct packed {
    logic [1:0]                     command;
    logic signed [NUMBER_WIDTH-1:0] number;
    logic [7:0]                     point_position;
  } in_word_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [2:0] active_digit;
    logic       digit_on;
    logic       running;
  } out_word_t;

  // Converter control and status
  typedef struct packed {
    logic start;
    logic hex;
    logic shift;
  } conv_ctrl_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } conv_stat_t;

  // Segment pattern a..g for a digit code; anything past the digits is a dash
  function automatic logic [7:0] seg_lookup(input logic [CODE_W-1:0] code);
    logic [7:0] pat;
    case (code)
      5'd0:    pat = 8'h3F;
      5'd1:    pat = 8'h06;
      5'd2:    pat = 8'h5B;
      5'd3:    pat = 8'h4F;
      5'd4:    pat = 8'h66;
      5'd5:    pat = 8'h6D;
      5'd6:    pat = 8'h7D;
      5'd7:    pat = 8'h07;
      5'd8:    pat = 8'h7F;
      5'd9:    pat = 8'h6F;
      5'd10:   pat = 8'h77;
      5'd11:   pat = 8'h7C;
      5'd12:   pat = 8'h39;
      5'd13:   pat = 8'h5E;
      5'd14:   pat = 8'h79;
      5'd15:   pat = 8'h71;
      default: pat = 8'h40;
    endcase
    return pat;
  endfunction

endpackage

// ===== src/mss_ram.sv =====
// ----------------------------------------------------------------------------
// mss_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/mss_conv.sv =====
// ----------------------------------------------------------------------------
// mss_conv: iterative binary to digit converter
// Shift-and-add-3 over two magnitude bits per cycle; hex skips the correction.
// ----------------------------------------------------------------------------
module mss_conv #(
  parameter int MAX_DIGITS = mss_pkg::MAX_DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mss_pkg::conv_ctrl_t             ctrl,
  input  logic [mss_pkg::NUMBER_WIDTH-1:0] mag,
  output mss_pkg::conv_stat_t             stat,
  output logic [4*MAX_DIGITS-1:0]         digits
);
  import mss_pkg::*;

  localparam int MAG_W = NUMBER_WIDTH + (NUMBER_WIDTH % 2);
  localparam int STEPS = MAG_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int DIG_W = 4 * MAX_DIGITS;

  logic [MAG_W-1:0] sh_r;
  logic [DIG_W-1:0] dig_r;
  logic             ovf_r;
  logic             hex_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIG_W:0]   step1;
  logic [DIG_W:0]   step2;

  // Correct each decimal digit, then shift one bit in; top bit falls out
  function automatic logic [DIG_W:0] dabble(input logic [DIG_W-1:0] d, input logic b,
                                            input logic hex);
    logic [DIG_W-1:0] adj;
    adj = d;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (!hex && (d[4*i +: 4] >= 4'd5)) begin
        adj[4*i +: 4] = d[4*i +: 4] + 4'd3;
      end
    end
    return {adj, b};
  endfunction

  always_comb begin
    step1 = dabble(dig_r, sh_r[MAG_W-1], hex_r);
    step2 = dabble(step1[DIG_W-1:0], sh_r[MAG_W-2], hex_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        sh_r   <= MAG_W'(mag);
        dig_r  <= '0;
        ovf_r  <= 1'b0;
        hex_r  <= ctrl.hex;
        cnt_r  <= CNT_W'(STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        sh_r  <= sh_r << 2;
        dig_r <= step2[DIG_W-1:0];
        ovf_r <= ovf_r | step1[DIG_W] | step2[DIG_W];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (ctrl.shift) begin
        dig_r <= dig_r >> 4;
      end
    end
  end

  assign stat   = '{done: done_r, ovf: ovf_r};
  assign digits = dig_r;

endmodule

// ===== src/multiplexed_seven_segment_scanner_top.sv =====
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_top: multiplexed seven-segment scanner
// Loads a signed number as digits into a small RAM and scans it out per tick.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | word
//   --------+-----------+----------------------+------------------------------
//   in_     | input     | in_valid / in_ready  | command, number, point
//   out_    | output    | out_valid / out_ready| segments, digit, on, running
//   cfg_    | input     | cfg_valid / cfg_ready| register index, data
//
// Words are taken one at a time. A load runs the converter, two magnitude bits
// per cycle, sizes the result in S_SIZE, then makes one digit RAM write per
// stored digit. A tick while scanning reads the digit RAM in S_READ; a tick
// while stopped, stop and the unused command go straight to S_DONE.
// Reset: synchronous, active low; clears scan state, pins and config to their
// reset values. The digit RAM is not cleared; only loaded entries are read.
// Stalls: a finished result sits in the output register while the next word
// is taken; the FSM holds in its final state only while that register is full and out_ready is low.
//
module multiplexed_seven_segment_scanner_top #(
  parameter int MAX_DIGITS = mss_pkg::MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mss_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mss_pkg::out_word_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mss_pkg::*;

  localparam int LEN_W = $clog2(MAX_DIGITS + 1);
  localparam int CUR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = (LEN_W > 4) ? LEN_W : 4;
  localparam int DIG_W = 4 * MAX_DIGITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_SIZE, S_WRITE, S_READ, S_DONE
  } state_t;

  state_t            state_r;

  // Configuration registers
  logic [3:0]        digit_count_r;
  logic              hex_mode_r;
  logic              zero_fill_r;
  logic              allow_sign_r;
  logic              invert_r;

  // Scan state
  logic [LEN_W-1:0]  stored_length_r;
  logic [CUR_W-1:0]  cursor_r;
  logic              scanning_r;
  logic [7:0]        point_index_r;

  // Display pins as last driven
  logic [7:0]        pin_pattern_r;
  logic [2:0]        pin_digit_r;
  logic              pin_on_r;

  // Load bookkeeping
  logic              neg_r;
  logic [LEN_W-1:0]  body_len_r;
  logic [LEN_W-1:0]  wr_pos_r;

  logic              out_valid_r;
  out_word_t         out_data_r;

  // Datapath signals
  logic              accept;
  logic              emit;
  logic [LEN_W-1:0]  lines;
  logic [CNT_W-1:0]  dc_ext;
  logic [LEN_W-1:0]  lim;
  logic [LEN_W-1:0]  inc;
  logic [CUR_W-1:0]  cursor_nxt;
  logic [CUR_W+2:0]  cur_ext;
  logic [NUMBER_WIDTH-1:0] num_u;
  logic [NUMBER_WIDTH-1:0] mag;
  logic              num_neg;
  logic [LEN_W-1:0]  hi;
  logic [LEN_W-1:0]  sig;
  logic [LEN_W-1:0]  target;
  logic [LEN_W-1:0]  body;
  logic [LEN_W:0]    total;
  logic [LEN_W-1:0]  store_len_nxt;
  logic [CODE_W-1:0] wr_code;
  logic              wr_last;
  logic [7:0]        tick_pat;
  logic [CODE_W-1:0] rd_code;
  logic              rd_en;
  conv_ctrl_t        conv_ctrl;
  conv_stat_t        conv_stat;
  logic [DIG_W-1:0]  digits;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit      = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    // Lines in use: zero acts as one, anything past the store as the store size
    dc_ext = CNT_W'(digit_count_r);
    if (dc_ext == '0) begin
      lines = LEN_W'(1);
    end else if (dc_ext > CNT_W'(MAX_DIGITS)) begin
      lines = LEN_W'(MAX_DIGITS);
    end else begin
      lines = LEN_W'(dc_ext);
    end
    lim = (stored_length_r < lines) ? stored_length_r : lines;

    // Advance the cursor, wrap at the scan limit
    inc = LEN_W'(cursor_r) + LEN_W'(1);
    if ((inc >= lim) || (inc >= LEN_W'(MAX_DIGITS))) begin
      cursor_nxt = '0;
    end else begin
      cursor_nxt = CUR_W'(inc);
    end
    cur_ext = {3'b000, cursor_r};

    // Magnitude of the incoming number
    num_u   = in_data.number;
    num_neg = num_u[NUMBER_WIDTH-1];
    mag     = num_neg ? ((~num_u) + NUMBER_WIDTH'(1)) : num_u;

    // Significant digits: highest nonzero digit, at least one, all of them on overflow
    hi = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (digits[4*i +: 4] != 4'd0) begin
        hi = LEN_W'(i + 1);
      end
    end
    if (conv_stat.ovf) begin
      sig = LEN_W'(MAX_DIGITS);
    end else if (hi == '0) begin
      sig = LEN_W'(1);
    end else begin
      sig = hi;
    end
    // Zero fill stops one place short of the lines when a sign is allowed
    target = lines - LEN_W'(allow_sign_r);
    body   = (zero_fill_r && (target > sig)) ? target : sig;
    total  = {1'b0, body} + (LEN_W+1)'(allow_sign_r && neg_r);
    store_len_nxt = (total > (LEN_W+1)'(MAX_DIGITS)) ? LEN_W'(MAX_DIGITS) : LEN_W'(total);

    // Digits below the body come from the converter, the place after is a dash
    wr_code = (wr_pos_r < body_len_r) ? {1'b0, digits[3:0]} : MINUS_CODE;
    wr_last = ((wr_pos_r + LEN_W'(1)) == stored_length_r);

    // Pattern for the digit just read back
    tick_pat = seg_lookup(rd_code);
    if ({8'h00, cursor_r} == {{CUR_W{1'b0}}, point_index_r}) begin
      tick_pat = tick_pat | POINT_BIT;
    end
  end

  assign rd_en = accept && (in_data.command == CMD_TICK) && scanning_r;

  assign conv_ctrl = '{
    start: accept && (in_data.command == CMD_LOAD),
    hex:   hex_mode_r,
    shift: (state_r == S_WRITE)
  };

  mss_conv #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (conv_ctrl),
    .mag    (mag),
    .stat   (conv_stat),
    .digits (digits)
  );

  mss_ram #(
    .WIDTH (CODE_W),
    .DEPTH (MAX_DIGITS)
  ) u_digit_ram (
    .clk     (clk),
    .wr_en   (state_r == S_WRITE),
    .wr_addr (wr_pos_r[CUR_W-1:0]),
    .wr_data (wr_code),
    .rd_en   (rd_en),
    .rd_addr (cursor_nxt),
    .rd_data (rd_code)
  );

  // Config writes must land only while idle; the user ensures this, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digit_count_r <= DIGITS_RST;
      hex_mode_r    <= 1'b0;
      zero_fill_r   <= 1'b0;
      allow_sign_r  <= 1'b0;
      invert_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DIGIT_COUNT: digit_count_r <= cfg_data;
        CFG_HEX_MODE:    hex_mode_r    <= cfg_data[0];
        CFG_ZERO_FILL:   zero_fill_r   <= cfg_data[0];
        CFG_ALLOW_SIGN:  allow_sign_r  <= cfg_data[0];
        CFG_INVERT_SEG:  invert_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Control FSM with scan state, pins and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      stored_length_r <= '0;
      cursor_r        <= '0;
      scanning_r      <= 1'b0;
      point_index_r   <= NO_POINT;
      pin_pattern_r   <= '0;
      pin_digit_r     <= '0;
      pin_on_r        <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      // Drop the taken word unless a new one replaces it on the same edge
      if (out_valid_r && out_ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (in_data.command)
              CMD_LOAD: begin
                neg_r         <= num_neg;
                point_index_r <= in_data.point_position;
                state_r       <= S_CONV;
              end
              CMD_TICK: begin
                if (scanning_r) begin
                  cursor_r <= cursor_nxt;
                  state_r  <= S_READ;
                end else begin
                  state_r  <= S_DONE;
                end
              end
              CMD_STOP: begin
                scanning_r    <= 1'b0;
                pin_pattern_r <= '0;
                pin_on_r      <= 1'b0;
                pin_digit_r   <= cur_ext[2:0];
                state_r       <= S_DONE;
              end
              default: begin
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_CONV: begin
          if (conv_stat.done) begin
            state_r <= S_SIZE;
          end
        end
        S_SIZE: begin
          body_len_r      <= body;
          stored_length_r <= store_len_nxt;
          wr_pos_r        <= '0;
          state_r         <= S_WRITE;
        end
        S_WRITE: begin
          wr_pos_r <= wr_pos_r + LEN_W'(1);
          if (wr_last) begin
            // Park on the last shown digit so the first tick shows digit zero
            cursor_r   <= CUR_W'(lim - LEN_W'(1));
            scanning_r <= 1'b1;
            state_r    <= S_DONE;
          end
        end
        S_READ: begin
          pin_pattern_r <= tick_pat;
          pin_digit_r   <= cur_ext[2:0];
          pin_on_r      <= 1'b1;
          state_r       <= S_DONE;
        end
        S_DONE: begin
          if (emit) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= '{
        segments:     invert_r ? ~pin_pattern_r : pin_pattern_r,
        active_digit: pin_digit_r,
        digit_on:     pin_on_r,
        running:      scanning_r
      };
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_scan_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    scanning_r |-> (stored_length_r != '0))
    else $error("scanning with an empty digit store");

  a_pin_on_scanning: assert property (@(posedge clk) disable iff (!rst_n)
    pin_on_r |-> scanning_r)
    else $error("digit line driven while stopped");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (wr_pos_r < stored_length_r))
    else $error("digit write past stored length");

  a_tick_reads: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == S_READ))
    else $error("tick read issued without read-back state");

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multiplexed seven-segment scanner
// Drives load, tick and stop words through the valid/ready input channel and
// checks every output word against a cycle-free model of the display pins.
// The register set changes between phases, and both sides idle at random except in the closing phase.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  // Command code the block treats as a no-op
  localparam logic [1:0] CMD_IDLE = 2'd3;

  localparam int DIGIT_SLOTS  = MAX_DIGITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 40;     // longest load plus some margin
  localparam int HOLD_AFTER   = 120;    // results seen before the long hold-off
  localparam int HOLD_CYCLES  = 96;
  localparam int PHASE_WORDS  = 65;

  typedef struct packed {
    logic [3:0] lines;
    logic       hex;
    logic       fill;
    logic       sign;
    logic       inv;
  } display_setup_t;

  // --------------------------------------------------------------------------
  // Display mirror: tracks registers, digit store, scan cursor and pins, and
  // keeps the pin words the block still owes, oldest first.
  // --------------------------------------------------------------------------
  class scanner_mirror;
    logic [3:0]  digit_count;
    logic        hex_mode, zero_fill, allow_sign, invert_seg;
    logic [4:0]  digits [DIGIT_SLOTS];
    int unsigned stored_len, cursor;
    logic        scanning;
    logic [7:0]  point_idx;
    logic [7:0]  pin_pat;
    logic [2:0]  pin_digit;
    logic        pin_on;
    out_word_t   pending_pins [$];
    int          errors;
    // a..g patterns for codes 0..15, then the minus sign
    logic [6:0]  glyphs [17] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
                                 7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71,
                                 7'h40};

    function new();
      digit_count = DIGITS_RST;
      hex_mode    = 1'b0;
      zero_fill   = 1'b0;
      allow_sign  = 1'b0;
      invert_seg  = 1'b0;
      foreach (digits[i]) digits[i] = '0;
      stored_len  = 0;
      cursor      = 0;
      scanning    = 1'b0;
      point_idx   = NO_POINT;
      pin_pat     = '0;
      pin_digit   = '0;
      pin_on      = 1'b0;
      errors      = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DIGIT_COUNT: digit_count = val;
        CFG_HEX_MODE:    hex_mode    = val[0];
        CFG_ZERO_FILL:   zero_fill   = val[0];
        CFG_ALLOW_SIGN:  allow_sign  = val[0];
        CFG_INVERT_SEG:  invert_seg  = val[0];
        default: ;
      endcase
    endfunction

    // Store a digit code; codes past the last slot are dropped
    function void push_code(inout int unsigned pos, input logic [4:0] code);
      if (pos < DIGIT_SLOTS) digits[pos] = code;
      pos++;
    endfunction

    // Advance the mirror by one accepted word and queue the pins it yields
    function void note_word(in_word_t w);
      logic [31:0] mag, base;
      int unsigned lines, lim, pos;
      int          fill;
      logic        negative;
      logic [4:0]  code;
      logic [7:0]  pat;
      out_word_t   want;
      // A digit count of zero acts as one, anything past the slots as all slots
      lines = (digit_count == 0) ? 1 :
              (digit_count > DIGIT_SLOTS) ? DIGIT_SLOTS : digit_count;
      lim   = (stored_len < lines) ? stored_len : lines;
      case (w.command)
        CMD_LOAD: begin
          base     = hex_mode ? 32'd16 : 32'd10;
          negative = w.number[31];
          mag      = negative ? -w.number : w.number;
          pos      = 0;
          do begin
            push_code(pos, 5'(mag % base));
            mag = mag / base;
          end while (mag != 0);
          if (zero_fill) begin
            // keep one place free for the sign when signs are allowed
            fill = int'(lines) - int'(pos) - (allow_sign ? 1 : 0);
            while (fill > 0) begin
              push_code(pos, 5'd0);
              fill--;
            end
          end
          if (allow_sign && negative) push_code(pos, MINUS_CODE);
          stored_len = (pos > DIGIT_SLOTS) ? DIGIT_SLOTS : pos;
          lim        = (stored_len < lines) ? stored_len : lines;
          // park on the last digit so the first tick shows digit 0
          cursor     = lim - 1;
          scanning   = 1'b1;
          point_idx  = w.point_position;
        end
        CMD_TICK: begin
          if (scanning) begin
            cursor++;
            if (cursor >= lim || cursor >= DIGIT_SLOTS) cursor = 0;
            code = digits[cursor];
            if (code > MINUS_CODE) code = MINUS_CODE;
            pat = {1'b0, glyphs[code]};
            if (cursor == point_idx) pat = pat | POINT_BIT;
            pin_pat   = pat;
            pin_digit = 3'(cursor);
            pin_on    = 1'b1;
          end
        end
        CMD_STOP: begin
          scanning  = 1'b0;
          pin_pat   = '0;
          pin_on    = 1'b0;
          pin_digit = 3'(cursor);
        end
        default: ;
      endcase
      want.segments     = invert_seg ? ~pin_pat : pin_pat;
      want.active_digit = pin_digit;
      want.digit_on     = pin_on;
      want.running      = scanning;
      pending_pins.insert(pending_pins.size(), want);
    endfunction

    task report(string what);
      $display("[%0t] pin mismatch: %s", $time, what);
      errors++;
    endtask

    task check_pins(out_word_t got);
      out_word_t want;
      if (pending_pins.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      want = pending_pins.pop_front();
      if (got.segments !== want.segments)
        report($sformatf("segments %h, want %h", got.segments, want.segments));
      if (got.active_digit !== want.active_digit)
        report($sformatf("active_digit %0d, want %0d", got.active_digit, want.active_digit));
      if (got.digit_on !== want.digit_on)
        report($sformatf("digit_on %b, want %b", got.digit_on, want.digit_on));
      if (got.running !== want.running)
        report($sformatf("running %b, want %b", got.running, want.running));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DIGIT_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  scanner_mirror sb = new();
  bit            steady = 1'b0;   // set for the closing phase: no idling at all
  int            results_seen = 0;
  int            cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multiplexed_seven_segment_scanner_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Watchdog: end the run if the block stops making progress
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result side: check each accepted word, then pick the next ready value.
  // One long hold-off lets the block fill up and back-pressure its input.
  // --------------------------------------------------------------------------
  initial begin : drain_pins
    bit held;
    int hold_left, stall_left;
    held       = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        sb.check_pins(out_data);
        results_seen++;
      end
      if (!held && results_seen >= HOLD_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        // start a stall burst, this cycle included; stall_left holds the rest
        stall_left = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic in_word_t word_of(logic [1:0] cmd, logic [31:0] num, logic [7:0] pt);
    in_word_t w;
    w.command        = cmd;
    w.number         = num;
    w.point_position = pt;
    return w;
  endfunction

  // Mix of short decimals, wide values, extremes and negatives
  function automatic logic [31:0] pick_number();
    logic [31:0] edges [4];
    edges = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 99);
      1:       return -$urandom_range(1, 99);
      2:       return $urandom;
      3:       return $urandom >> $urandom_range(0, 31);
      4:       return edges[$urandom_range(0, 3)];
      default: return -($urandom >> $urandom_range(1, 31));
    endcase
  endfunction

  // Mostly a visible digit, sometimes none, sometimes any byte
  function automatic logic [7:0] pick_point();
    case ($urandom_range(0, 9))
      0:       return NO_POINT;
      1:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 7));
    endcase
  endfunction

  // Offer one word, hold it until taken, then maybe drop valid for a burst
  task automatic send_word(in_word_t w);
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every owed word has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_pins.size() != 0);
  endtask

  // Write all five registers back to back; the block is idle here
  task automatic program_display(display_setup_t s);
    logic [CFG_IDX_W-1:0]  regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{CFG_DIGIT_COUNT, CFG_HEX_MODE, CFG_ZERO_FILL, CFG_ALLOW_SIGN, CFG_INVERT_SEG};
    vals = '{s.lines, {3'b000, s.hex}, {3'b000, s.fill}, {3'b000, s.sign}, {3'b000, s.inv}};
    for (int i = 0; i < 5; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly a load followed by a run of ticks, now and then a stop; the
  // rest is noise with any command and any field bits.
  task automatic run_mix(int count);
    int sent;
    in_word_t w;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 6) != 0) begin
        send_word(word_of(CMD_LOAD, pick_number(), pick_point()));
        sent++;
        repeat ($urandom_range(1, 10)) begin
          send_word(word_of(CMD_TICK, $urandom, 8'($urandom)));
          sent++;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_word(word_of(CMD_STOP, $urandom, 8'($urandom)));
          sent++;
        end
      end else begin
        w = word_of(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
        send_word(w);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : run_display
    display_setup_t phases [8];
    phases[0] = '{4'd0,  1'b0, 1'b0, 1'b0, 1'b0};
    phases[1] = '{4'd15, 1'b1, 1'b1, 1'b1, 1'b1};
    phases[2] = '{4'd1,  1'b0, 1'b1, 1'b1, 1'b1};
    phases[3] = '{4'd8,  1'b0, 1'b1, 1'b1, 1'b0};
    phases[4] = '{4'd3,  1'b1, 1'b0, 1'b1, 1'b0};
    phases[5] = display_setup_t'(8'($urandom));
    phases[6] = display_setup_t'(8'($urandom));
    phases[7] = '{4'd8,  1'b0, 1'b0, 1'b1, 1'b1};

    // Hold reset asserted, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: four lines, decimal, no fill, no sign, plain segments.
    // Tick before any load, unused command, stop from idle.
    send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    send_word(word_of(CMD_IDLE, 32'h5A5A_5A5A, 8'hA5));
    send_word(word_of(CMD_STOP, 32'hFFFF_FFFF, 8'hFF));
    // Ten decimal digits: store saturates, scan wraps at four lines
    send_word(word_of(CMD_LOAD, 32'h7FFF_FFFF, NO_POINT));
    repeat (5) send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    // Most negative number without sign support, point on digit 0
    send_word(word_of(CMD_LOAD, 32'h8000_0000, 8'd0));
    send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    // Zero: one digit, ticks stay on it
    send_word(word_of(CMD_LOAD, 32'h0, 8'd0));
    repeat (2) send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    send_word(word_of(CMD_LOAD, 32'hFFFF_FFFF, 8'd1));
    send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    // Stop blanks; a tick while stopped changes nothing
    send_word(word_of(CMD_STOP, 32'h0, 8'h00));
    send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    settle();

    // All lines, hex, fill, sign, inverted: dash and padding, dropped minus
    program_display('{4'd8, 1'b1, 1'b1, 1'b1, 1'b1});
    send_word(word_of(CMD_LOAD, 32'hFFFF_FFFF, 8'd7));
    repeat (2) send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    send_word(word_of(CMD_LOAD, 32'h8000_0000, NO_POINT));
    send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    send_word(word_of(CMD_LOAD, 32'h7EDC_BA98, 8'd3));
    repeat (2) send_word(word_of(CMD_TICK, 32'h0, 8'h00));
    send_word(word_of(CMD_STOP, 32'h0, 8'h00));
    settle();

    // Random phases; the last one runs with no idling on either side
    for (int p = 0; p < 8; p++) begin
      if (p == 7) steady = 1'b1;
      program_display(phases[p]);
      run_mix(PHASE_WORDS);
      settle();
    end

    // Give any stray word time to show up before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
